FILE: rtl/core/sat_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// summed-area table query unit. No dependencies.
`timescale 1ns / 1ps

package sat_pkg;

  // Matrix geometry and arithmetic widths
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_BITS   = 6;
  localparam int COL_BITS   = 6;
  localparam int CNT_BITS   = 7;
  localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
  localparam int VALUE_BITS = 16;
  localparam int RUN_BITS   = 22;
  localparam int TABLE_BITS = 28;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COL_COUNT = 2'd1;

  // Query status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_BAD_RECT   = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;    // capture the accepted transaction
    logic ld_rd;    // read the entry above the load position
    logic ld_wr;    // write the new table entry, advance position
    logic q_check;  // register query status, clear accumulator
    logic q_rd;     // issue one corner read
    logic finish;   // present the query result
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic q_err;    // query fails the completeness or corner checks
    logic rd_last;  // the current corner read is the last one
  } dp_sts_t;

endpackage

FILE: rtl/core/sat_ctrl.sv
// Sequencing state machine for loads and queries.
// Depends on sat_pkg for the command and status types.
`timescale 1ns / 1ps

module sat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  sat_pkg::dp_sts_t  sts,
  output sat_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LD_RD = 3'd1;
  localparam logic [2:0] S_LD_WR = 3'd2;
  localparam logic [2:0] S_Q_CHK = 3'd3;
  localparam logic [2:0] S_Q_RD  = 3'd4;
  localparam logic [2:0] S_Q_ACC = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = mode ? S_Q_CHK : S_LD_RD;
        end
      end
      S_LD_RD: begin
        cmd.ld_rd  = 1'b1;
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr  = 1'b1;
        state_next = S_IDLE;
      end
      S_Q_CHK: begin
        cmd.q_check = 1'b1;
        state_next  = sts.q_err ? S_DONE : S_Q_RD;
      end
      S_Q_RD: begin
        cmd.q_rd = 1'b1;
        if (sts.rd_last) state_next = S_Q_ACC;
      end
      S_Q_ACC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/core/sat_dp.sv
// Datapath: configuration, load position, running row sum, table memory,
// corner-read accumulator and result registers. Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  sat_pkg::dp_cmd_t                         cmd,
  output sat_pkg::dp_sts_t                         sts,
  input  logic                                     cfg_we,
  input  logic [sat_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [sat_pkg::CNT_BITS-1:0]             cfg_data,
  input  logic                                     mode,
  input  logic signed [sat_pkg::VALUE_BITS-1:0]    value,
  input  logic [sat_pkg::ROW_BITS-1:0]             top_row,
  input  logic [sat_pkg::COL_BITS-1:0]             left_col,
  input  logic [sat_pkg::ROW_BITS-1:0]             bottom_row,
  input  logic [sat_pkg::COL_BITS-1:0]             right_col,
  output logic                                     result_valid,
  output logic signed [sat_pkg::TABLE_BITS-1:0]    region_sum,
  output logic [1:0]                               status
);

  localparam int CB = sat_pkg::CNT_BITS;
  localparam int RB = sat_pkg::ROW_BITS;
  localparam int CL = sat_pkg::COL_BITS;
  localparam int TB = sat_pkg::TABLE_BITS;
  localparam int UB = sat_pkg::RUN_BITS;
  localparam int VB = sat_pkg::VALUE_BITS;
  localparam logic [CB-1:0] ROWS_MAX = CB'(sat_pkg::MAX_ROWS);
  localparam logic [CB-1:0] COLS_MAX = CB'(sat_pkg::MAX_COLS);

  logic [CB-1:0] row_count;
  logic [CB-1:0] col_count;
  logic [CB-1:0] rows;
  logic [CB-1:0] cols;

  logic [RB-1:0] load_row;
  logic [CL-1:0] load_col;
  logic signed [UB-1:0] run_sum;
  logic table_complete;

  logic signed [VB-1:0] value_q;
  logic [RB-1:0] top_q;
  logic [CL-1:0] left_q;
  logic [RB-1:0] bottom_q;
  logic [CL-1:0] right_q;

  logic [TB-1:0] mem [0:(1 << sat_pkg::ADDR_BITS)-1];
  logic [sat_pkg::ADDR_BITS-1:0] raddr;
  logic [TB-1:0] rdata;

  logic [1:0] step;
  logic       pend_valid;
  logic       pend_use;
  logic       pend_neg;
  logic       use_now;
  logic       neg_now;
  logic signed [TB-1:0] acc;
  logic [1:0] q_status;

  logic signed [UB-1:0] run_next;
  logic signed [TB-1:0] above;
  logic signed [TB-1:0] entry_next;
  logic [CB-1:0] col_inc;
  logic [CB-1:0] row_inc;
  logic [1:0]    chk_status;

  // Clamp the size registers into the legal range
  assign rows = (row_count == '0) ? CB'(1) : ((row_count > ROWS_MAX) ? ROWS_MAX : row_count);
  assign cols = (col_count == '0) ? CB'(1) : ((col_count > COLS_MAX) ? COLS_MAX : col_count);

  // Load arithmetic
  assign run_next   = run_sum + {{(UB-VB){value_q[VB-1]}}, value_q};
  assign above      = (load_row == '0) ? '0 : $signed(rdata);
  assign entry_next = above + {{(TB-UB){run_next[UB-1]}}, run_next};
  assign col_inc    = {1'b0, load_col} + CB'(1);
  assign row_inc    = {1'b0, load_row} + CB'(1);

  // Query status: completeness first, then corner order and range
  always_comb begin
    if (!table_complete) begin
      chk_status = sat_pkg::ST_INCOMPLETE;
    end else if ((top_q > bottom_q) || (left_q > right_q) ||
                 ({1'b0, bottom_q} >= rows) || ({1'b0, right_q} >= cols)) begin
      chk_status = sat_pkg::ST_BAD_RECT;
    end else begin
      chk_status = sat_pkg::ST_OK;
    end
  end

  assign sts.q_err   = (chk_status != sat_pkg::ST_OK);
  assign sts.rd_last = (step == 2'd3);

  // Corner read address and sign for the current step; a load read overrides the address
  always_comb begin
    case (step)
      2'd0: begin
        raddr   = {bottom_q, right_q};
        use_now = 1'b1;
        neg_now = 1'b0;
      end
      2'd1: begin
        raddr   = {top_q - RB'(1), right_q};
        use_now = (top_q != '0);
        neg_now = 1'b1;
      end
      2'd2: begin
        raddr   = {bottom_q, left_q - CL'(1)};
        use_now = (left_q != '0);
        neg_now = 1'b1;
      end
      default: begin
        raddr   = {top_q - RB'(1), left_q - CL'(1)};
        use_now = (top_q != '0) && (left_q != '0);
        neg_now = 1'b0;
      end
    endcase
    if (cmd.ld_rd) begin
      raddr = {load_row - RB'(1), load_col};
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      mem[{load_row, load_col}] <= entry_next;
    end
    rdata <= mem[raddr];
  end

  // Capture the transaction fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      value_q  <= value;
      top_q    <= top_row;
      left_q   <= left_col;
      bottom_q <= bottom_row;
      right_q  <= right_col;
    end
  end

  // Configuration, load position, running sum and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= ROWS_MAX;
      col_count      <= COLS_MAX;
      load_row       <= '0;
      load_col       <= '0;
      run_sum        <= '0;
      table_complete <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == sat_pkg::CFG_ROW_COUNT || cfg_index == sat_pkg::CFG_COL_COUNT) begin
        if (cfg_index == sat_pkg::CFG_ROW_COUNT) row_count <= cfg_data;
        else col_count <= cfg_data;
        load_row       <= '0;
        load_col       <= '0;
        run_sum        <= '0;
        table_complete <= 1'b0;
      end
    end else if (cmd.latch && !mode) begin
      // start over when the position is outside the current size
      table_complete <= 1'b0;
      if (({1'b0, load_row} >= rows) || ({1'b0, load_col} >= cols)) begin
        load_row <= '0;
        load_col <= '0;
        run_sum  <= '0;
      end
    end else if (cmd.ld_wr) begin
      if (col_inc >= cols) begin
        load_col <= '0;
        run_sum  <= '0;
        if (row_inc >= rows) begin
          load_row       <= '0;
          table_complete <= 1'b1;
        end else begin
          load_row <= row_inc[RB-1:0];
        end
      end else begin
        load_col <= col_inc[CL-1:0];
        run_sum  <= run_next;
      end
    end
  end

  // Corner read step counter and pending-read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.q_rd;
      if (cmd.q_check) step <= '0;
      else if (cmd.q_rd) step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    pend_use <= use_now;
    pend_neg <= neg_now;
  end

  // Accumulate each corner as its read data returns
  always_ff @(posedge clk) begin
    if (cmd.q_check) begin
      acc      <= '0;
      q_status <= chk_status;
    end else if (pend_valid && pend_use) begin
      acc <= pend_neg ? (acc - $signed(rdata)) : (acc + $signed(rdata));
    end
  end

  // Result registers, strobe for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= q_status;
      region_sum <= (q_status == sat_pkg::ST_OK) ? acc : '0;
    end
  end

endmodule

FILE: rtl/core/summed_area_table_query_unit.sv
// Top level of the summed-area table query unit: joins controller and datapath.
// Depends on sat_pkg, sat_ctrl and sat_dp.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; mode 0 loads the
// next matrix element in raster order, mode 1 queries an inclusive rectangle.
// A load passes through accept, read of the entry above and write of the new
// entry, an order set by the single read and write port of the 4096-entry table
// memory. A query passes from accept through a check state, four corner reads
// through the same read port, a state for the last read data, and the result
// state; result_valid is high the cycle after, for one cycle, and cannot be held
// off, so the receiver must take it then. A query that fails the checks skips
// the reads and goes from the check state straight to the result state before
// its strobe.
// The next transaction may be started in the cycle the result is shown.
// Writes to the row or column count restart loading; the table needs no clearing pass.

module summed_area_table_query_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode,
  input  logic signed [sat_pkg::VALUE_BITS-1:0]  value,
  input  logic [sat_pkg::ROW_BITS-1:0]           top_row,
  input  logic [sat_pkg::COL_BITS-1:0]           left_col,
  input  logic [sat_pkg::ROW_BITS-1:0]           bottom_row,
  input  logic [sat_pkg::COL_BITS-1:0]           right_col,
  input  logic                                   cfg_we,
  input  logic [sat_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [sat_pkg::CNT_BITS-1:0]           cfg_data,
  output logic                                   result_valid,
  output logic signed [sat_pkg::TABLE_BITS-1:0]  region_sum,
  output logic [1:0]                             status
);

  sat_pkg::dp_cmd_t cmd;
  sat_pkg::dp_sts_t sts;

  // Sequencer
  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath and table memory
  sat_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .value        (value),
    .top_row      (top_row),
    .left_col     (left_col),
    .bottom_row   (bottom_row),
    .right_col    (right_col),
    .result_valid (result_valid),
    .region_sum   (region_sum),
    .status       (status)
  );

endmodule

FILE: rtl/core/sat_checker.sv
// Port-level checks for the summed-area table query unit, bound to the top.
// Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic                                   mode,
  input logic                                   result_valid,
  input logic signed [sat_pkg::TABLE_BITS-1:0]  region_sum,
  input logic [1:0]                             status
);

  // Failed queries report a zero sum
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != sat_pkg::ST_OK) |-> (region_sum == '0))
    else $error("nonzero sum on failed query");

  // An accepted transaction occupies the unit for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after accept");

  // Results are single-cycle strobes, never back to back
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // A load transaction produces no result
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !mode) |=> !result_valid ##1 !result_valid ##1 !result_valid)
    else $error("result after load transaction");

endmodule

bind summed_area_table_query_unit sat_checker u_sat_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .result_valid (result_valid),
  .region_sum   (region_sum),
  .status       (status)
);

FILE: test/tb.sv
// Self-checking testbench for summed_area_table_query_unit: loads random matrices,
// queries rectangle sums and compares every result against an in-bench predictor.
// Depends on sat_pkg and the RTL of the query unit.
`timescale 1ns / 1ps

module tb;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  // index with no register behind it
  localparam logic [sat_pkg::CFG_IDX_BITS-1:0] CFG_NO_REG = 2'd2;
  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_FROM  = 1600;

  typedef struct packed {
    logic signed [sat_pkg::TABLE_BITS-1:0] sum;
    logic [1:0]                            st;
  } region_result_t;

  // Predict rectangle sums from the loaded matrix and check returned results
  class region_scoreboard;
    logic signed [sat_pkg::TABLE_BITS-1:0] sum_tbl [0:sat_pkg::MAX_ROWS*sat_pkg::MAX_COLS-1];
    int unsigned                           ld_row;
    int unsigned                           ld_col;
    logic signed [sat_pkg::RUN_BITS-1:0]   run_sum;
    bit                                    done;
    logic [sat_pkg::CNT_BITS-1:0]          rows_reg;
    logic [sat_pkg::CNT_BITS-1:0]          cols_reg;
    region_result_t                        expected_q[$];
    int                                    errors;

    function void restart();
      ld_row  = 0;
      ld_col  = 0;
      run_sum = '0;
      done    = 1'b0;
    endfunction

    function void reset_state();
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      errors   = 0;
      restart();
    endfunction

    function void write_reg(logic [sat_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [sat_pkg::CNT_BITS-1:0] d);
      if (idx == sat_pkg::CFG_ROW_COUNT) begin
        rows_reg = d;
        restart();
      end else if (idx == sat_pkg::CFG_COL_COUNT) begin
        cols_reg = d;
        restart();
      end
    endfunction

    function int unsigned span(logic [sat_pkg::CNT_BITS-1:0] r, int unsigned lim);
      if (r == 0) return 1;
      return (r > lim) ? lim : int'(r);
    endfunction

    function int unsigned eff_rows();
      return span(rows_reg, sat_pkg::MAX_ROWS);
    endfunction

    function int unsigned eff_cols();
      return span(cols_reg, sat_pkg::MAX_COLS);
    endfunction

    function logic signed [sat_pkg::TABLE_BITS-1:0] entry(int unsigned r, int unsigned c);
      return sum_tbl[r*sat_pkg::MAX_COLS + c];
    endfunction

    // Apply one accepted transaction: build a table entry or queue a query result
    function void note_item(logic m, logic signed [sat_pkg::VALUE_BITS-1:0] v,
                            logic [sat_pkg::ROW_BITS-1:0] t,
                            logic [sat_pkg::COL_BITS-1:0] l,
                            logic [sat_pkg::ROW_BITS-1:0] b,
                            logic [sat_pkg::COL_BITS-1:0] rc);
      int unsigned                           rows;
      int unsigned                           cols;
      logic signed [sat_pkg::TABLE_BITS-1:0] above;
      logic signed [sat_pkg::TABLE_BITS-1:0] s;
      region_result_t                        res;
      rows = eff_rows();
      cols = eff_cols();
      if (m == MODE_LOAD) begin
        if (ld_row >= rows || ld_col >= cols) restart();
        done    = 1'b0;
        run_sum = run_sum + v;
        above   = (ld_row > 0) ? entry(ld_row - 1, ld_col) : '0;
        sum_tbl[ld_row*sat_pkg::MAX_COLS + ld_col] = above + run_sum;
        ld_col++;
        if (ld_col >= cols) begin
          ld_col  = 0;
          run_sum = '0;
          ld_row++;
          if (ld_row >= rows) begin
            ld_row = 0;
            done   = 1'b1;
          end
        end
      end else begin
        res.sum = '0;
        if (!done) begin
          res.st = sat_pkg::ST_INCOMPLETE;
        end else if (t > b || l > rc || b >= rows || rc >= cols) begin
          res.st = sat_pkg::ST_BAD_RECT;
        end else begin
          res.st = sat_pkg::ST_OK;
          s = entry(b, rc);
          if (t > 0) s = s - entry(t - 1, rc);
          if (l > 0) s = s - entry(b, l - 1);
          if (t > 0 && l > 0) s = s + entry(t - 1, l - 1);
          res.sum = s;
        end
        expected_q.push_back(res);
      end
    endfunction

    function void fail_note();
      errors++;
    endfunction

    // Compare one result strobe against the oldest pending expectation
    function void check_result(logic signed [sat_pkg::TABLE_BITS-1:0] got_sum,
                               logic [1:0] got_st);
      region_result_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: region_sum %0d status %0d", got_sum, got_st);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got_sum !== exp_res.sum || got_st !== exp_res.st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: region_sum exp %0d got %0d, status exp %0d got %0d",
                   exp_res.sum, got_sum, exp_res.st, got_st);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                   clk;
  logic                                   rst;
  logic                                   start;
  logic                                   busy;
  logic                                   mode;
  logic signed [sat_pkg::VALUE_BITS-1:0]  value;
  logic [sat_pkg::ROW_BITS-1:0]           top_row;
  logic [sat_pkg::COL_BITS-1:0]           left_col;
  logic [sat_pkg::ROW_BITS-1:0]           bottom_row;
  logic [sat_pkg::COL_BITS-1:0]           right_col;
  logic                                   cfg_we;
  logic [sat_pkg::CFG_IDX_BITS-1:0]       cfg_index;
  logic [sat_pkg::CNT_BITS-1:0]           cfg_data;
  logic                                   result_valid;
  logic signed [sat_pkg::TABLE_BITS-1:0]  region_sum;
  logic [1:0]                             status;

  region_scoreboard sb;
  int               sent;
  bit               quiet;

  summed_area_table_query_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .top_row      (top_row),
    .left_col     (left_col),
    .bottom_row   (bottom_row),
    .right_col    (right_col),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .region_sum   (region_sum),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Record every accepted transaction
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_item(mode, value, top_row, left_col, bottom_row, right_col);
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result(region_sum, status);
  end

  // Drop start and keep it low, with n giving the length of the gap
  task automatic idle(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one transaction and wait until it is taken
  task automatic send_item(input logic m, input logic signed [sat_pkg::VALUE_BITS-1:0] v,
                           input logic [sat_pkg::ROW_BITS-1:0] t,
                           input logic [sat_pkg::COL_BITS-1:0] l,
                           input logic [sat_pkg::ROW_BITS-1:0] b,
                           input logic [sat_pkg::COL_BITS-1:0] rc);
    if (!quiet && $urandom_range(0, 4) == 0) idle($urandom_range(1, 10));
    @(negedge clk);
    start      = 1'b1;
    mode       = m;
    value      = v;
    top_row    = t;
    left_col   = l;
    bottom_row = b;
    right_col  = rc;
    do @(posedge clk); while (busy);
    sent++;
    if (sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic load(input logic signed [sat_pkg::VALUE_BITS-1:0] v);
    send_item(MODE_LOAD, v, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic query(input logic [sat_pkg::ROW_BITS-1:0] t,
                       input logic [sat_pkg::COL_BITS-1:0] l,
                       input logic [sat_pkg::ROW_BITS-1:0] b,
                       input logic [sat_pkg::COL_BITS-1:0] rc);
    send_item(MODE_QUERY, 16'($urandom), t, l, b, rc);
  endtask

  // Wait until every result is back and the last load has retired
  task automatic drain();
    idle(1);
    while (sb.pending() > 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [sat_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [sat_pkg::CNT_BITS-1:0] d);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [sat_pkg::VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly in-range rectangles, some with random corners
  task automatic rand_query();
    int unsigned rows;
    int unsigned cols;
    int unsigned t;
    int unsigned l;
    rows = sb.eff_rows();
    cols = sb.eff_cols();
    if ($urandom_range(0, 4) == 0) begin
      query(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
    end else begin
      t = $urandom_range(0, rows - 1);
      l = $urandom_range(0, cols - 1);
      query(6'(t), 6'(l), 6'($urandom_range(t, rows - 1)), 6'($urandom_range(l, cols - 1)));
    end
  endtask

  // Load count elements, with an occasional query slipped in
  task automatic load_run(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) rand_query();
      load(rand_value());
    end
  endtask

  // One phase: resize (set sizes first, random after), fill the table, query it, maybe reload it in two parts
  task automatic run_phase(input int unsigned phase_no);
    logic [sat_pkg::CNT_BITS-1:0] r_cfg;
    logic [sat_pkg::CNT_BITS-1:0] c_cfg;
    int unsigned                  n;
    int unsigned                  part;
    case (phase_no)
      0: begin r_cfg = 7'd0;   c_cfg = 7'd127; end
      1: begin r_cfg = 7'd64;  c_cfg = 7'd1;   end
      2: begin r_cfg = 7'd1;   c_cfg = 7'd1;   end
      3: begin r_cfg = 7'd100; c_cfg = 7'd2;   end
      default: begin
        r_cfg = 7'($urandom_range(1, 8));
        c_cfg = 7'($urandom_range(1, 8));
        if ($urandom_range(0, 9) == 0) begin
          r_cfg = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
          c_cfg = 7'($urandom_range(1, 2));
        end
      end
    endcase
    drain();
    if (phase_no < 4 || $urandom_range(0, 3) != 0) begin
      write_cfg(sat_pkg::CFG_ROW_COUNT, r_cfg);
      write_cfg(sat_pkg::CFG_COL_COUNT, c_cfg);
    end else if ($urandom_range(0, 1) == 0) begin
      write_cfg(sat_pkg::CFG_ROW_COUNT, r_cfg);
    end else begin
      write_cfg(sat_pkg::CFG_COL_COUNT, c_cfg);
    end
    n = sb.eff_rows() * sb.eff_cols();
    load_run(n);
    repeat ($urandom_range(4, 16)) rand_query();
    if ($urandom_range(0, 3) == 0) begin
      part = $urandom_range(1, n);
      load_run(part);
      repeat ($urandom_range(1, 2)) rand_query();
      load_run(n - part);
      repeat ($urandom_range(2, 8)) rand_query();
    end
  endtask

  initial begin
    int unsigned phase_no;
    sb         = new();
    sb.reset_state();
    sent       = 0;
    quiet      = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_LOAD;
    value      = '0;
    top_row    = '0;
    left_col   = '0;
    bottom_row = '0;
    right_col  = '0;
    cfg_we     = 1'b0;
    cfg_index  = sat_pkg::CFG_ROW_COUNT;
    cfg_data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: query before any table exists
    query(0, 0, 0, 0);
    drain();
    write_cfg(sat_pkg::CFG_ROW_COUNT, 7'd2);
    write_cfg(sat_pkg::CFG_COL_COUNT, 7'd3);
    query(0, 0, 1, 2);
    // Fill a 2x3 matrix with extreme and alternating-bit values
    load(16'sh7fff);
    load(16'sh8000);
    load(-16'sd1);
    load(16'sh5555);
    load(16'shaaaa);
    load(16'sd1);
    query(0, 0, 1, 2);
    query(1, 2, 1, 2);
    query(1, 1, 1, 2);
    query(0, 1, 0, 1);
    // Inverted and out-of-range corners
    query(1, 0, 0, 0);
    query(0, 2, 0, 1);
    query(0, 0, 2, 0);
    query(0, 0, 0, 3);
    query(63, 63, 63, 63);
    query(0, 0, 63, 63);
    // A write to an unused index leaves the table intact
    drain();
    write_cfg(CFG_NO_REG, 7'h55);
    query(0, 0, 1, 2);
    // A load after completion starts a new matrix
    load(16'sd0);
    query(0, 0, 0, 0);

    phase_no = 0;
    while (sent < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    idle(1);
    while (sb.pending() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Bound the run time
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: summed_area_table_query_unit.f
rtl/core/sat_pkg.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_dp.sv
rtl/core/summed_area_table_query_unit.sv
rtl/core/sat_checker.sv
test/tb.sv
